[src/jac_pkg.sv]
package jac_pkg;

    // Field widths of the sample, result and configuration channels.
    localparam int RAW_W      = 12;
    localparam int OUT_W      = 8;
    localparam int HEAD_W     = 3;
    localparam int ORIENT_W   = 2;
    localparam int THRESH_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_REST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_REST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DEAD_ZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DEAD_ZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd5;

    // Register values after reset.
    localparam logic [RAW_W-1:0]    RST_X_REST      = 12'd2048;
    localparam logic [RAW_W-1:0]    RST_Y_REST      = 12'd2048;
    localparam logic [RAW_W-1:0]    RST_X_DEAD_ZONE = 12'd50;
    localparam logic [RAW_W-1:0]    RST_Y_DEAD_ZONE = 12'd35;
    localparam logic [ORIENT_W-1:0] RST_ORIENTATION = 2'd0;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD   = 7'd40;

    // Mounting rotation codes.
    localparam logic [ORIENT_W-1:0] ORIENT_0   = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_90  = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_180 = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_270 = 2'd3;

    // Direction classes.
    localparam logic [HEAD_W-1:0] HEAD_NONE  = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 3'd2;
    localparam logic [HEAD_W-1:0] HEAD_UP    = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 3'd4;

endpackage

[src/jac_if.sv]
// Sample channel: two axis readings and the button level.
interface jac_in_if;
    import jac_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             button_level;

    modport source (output valid, output raw_x, output raw_y, output button_level,
                    input ready);
    modport sink   (input valid, input raw_x, input raw_y, input button_level,
                    output ready);
endinterface

// Result channel: rotated axis values, press flag and direction class.
interface jac_out_if;
    import jac_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  x_out;
    logic signed [OUT_W-1:0]  y_out;
    logic                     press_event;
    logic        [HEAD_W-1:0] heading;

    modport source (output valid, output x_out, output y_out, output press_event,
                    output heading, input ready);
    modport sink   (input valid, input x_out, input y_out, input press_event,
                    input heading, output ready);
endinterface

// Configuration write channel.
interface jac_cfg_if;
    import jac_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/jac_axis.sv]
module jac_axis #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int OUT_SCALE      = 100
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [jac_pkg::RAW_W-1:0]              raw,
    input  logic [jac_pkg::RAW_W-1:0]              rest,
    input  logic [jac_pkg::RAW_W-1:0]              dead_zone,
    output logic                                   done,
    output logic signed [$clog2(OUT_SCALE+1):0]    value
);
    import jac_pkg::*;

    // Quotient never exceeds OUT_SCALE, so QW quotient bits suffice.
    localparam int QW   = $clog2(OUT_SCALE + 1);
    localparam int SW   = QW + 1;
    localparam int FW   = $clog2(ADC_FULL_SCALE + 1);
    localparam int CW   = (FW > RAW_W) ? FW : RAW_W;
    localparam int NW   = RAW_W + QW;
    localparam int DSW  = CW + QW - 1;
    localparam int AW   = (NW > DSW) ? NW : DSW;
    localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [CW-1:0] FS_C  = CW'(ADC_FULL_SCALE);
    localparam logic [NW-1:0] OS_N  = NW'(OUT_SCALE);
    localparam logic [SW-1:0] OS_S  = SW'(OUT_SCALE);

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_SAT,
        MODE_UP,
        MODE_DOWN
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t            state_reg;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNTW-1:0]   cnt_reg;
    logic [AW-1:0]     rem_reg;
    logic [AW-1:0]     dsh_reg;
    logic [QW-1:0]     q_reg;
    logic              done_reg;

    logic              above;
    logic [RAW_W-1:0]  delta;
    logic [RAW_W-1:0]  base;
    logic [NW-1:0]     num;
    logic [CW-1:0]     divisor;
    logic              take;

    // Classify the reading and form the numerator and divisor of the scaling.
    always_comb
    begin
        above   = raw > rest;
        delta   = above ? (raw - rest) : (rest - raw);
        base    = above ? delta : raw;
        num     = NW'(base) * OS_N;
        divisor = above ? (FS_C - CW'(rest)) : CW'(rest);
        if (delta < dead_zone)
        begin
            mode_next = MODE_ZERO;
        end
        else if (above)
        begin
            if ((CW'(raw) >= FS_C) || (CW'(rest) >= FS_C))
            begin
                mode_next = MODE_SAT;
            end
            else
            begin
                mode_next = MODE_UP;
            end
        end
        else if (rest == '0)
        begin
            mode_next = MODE_ZERO;
        end
        else
        begin
            mode_next = MODE_DOWN;
        end
    end

    // One quotient bit per cycle: try the shifted divisor against the remainder.
    assign take = rem_reg >= dsh_reg;

    // Sequencer of the restoring divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_ZERO;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        mode_reg  <= mode_next;
                        rem_reg   <= AW'(num);
                        dsh_reg   <= AW'(divisor) << (QW - 1);
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    q_reg   <= QW'({q_reg, take});
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(QW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Final axis value from the quotient and the reading's class.
    always_comb
    begin
        case (mode_reg)
            MODE_SAT:  value = $signed(OS_S);
            MODE_UP:   value = $signed({1'b0, q_reg});
            MODE_DOWN: value = $signed({1'b0, q_reg}) - $signed(OS_S);
            default:   value = '0;
        endcase
    end

    assign done = done_reg;

endmodule

[src/joystick_axis_conditioner.sv]
// A sample's result passes through the bit-serial axis dividers, which produce
// QW = clog2(OUT_SCALE + 1) quotient bits, then the result and output registers.
// A new sample is taken only once the last result has moved to the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, asynchronous) restores the register defaults, marks the
// button released and empties the output register.
module joystick_axis_conditioner #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int OUT_SCALE      = 100
) (
    input  logic      clk,
    input  logic      rst_n,
    jac_cfg_if.sink   cfg,
    jac_in_if.sink    sample,
    jac_out_if.source result
);
    import jac_pkg::*;

    localparam int SW = $clog2(OUT_SCALE + 1) + 1;
    localparam int EW = (SW > 9) ? SW : 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUT
    } state_t;

    // Configuration registers.
    logic [RAW_W-1:0]    x_rest_reg;
    logic [RAW_W-1:0]    y_rest_reg;
    logic [RAW_W-1:0]    x_dead_zone_reg;
    logic [RAW_W-1:0]    y_dead_zone_reg;
    logic [ORIENT_W-1:0] orientation_reg;
    logic [THRESH_W-1:0] threshold_reg;

    state_t              state_reg;
    logic [RAW_W-1:0]    raw_x_reg;
    logic [RAW_W-1:0]    raw_y_reg;
    logic                start_reg;
    logic                last_button_reg;
    logic                press_reg;
    logic [OUT_W-1:0]    res_x_reg;
    logic [OUT_W-1:0]    res_y_reg;
    logic                res_press_reg;
    logic [HEAD_W-1:0]   res_head_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_x_reg;
    logic [OUT_W-1:0]    out_y_reg;
    logic                out_press_reg;
    logic [HEAD_W-1:0]   out_head_reg;

    logic                x_done;
    logic                y_done;
    logic signed [SW-1:0] x_val;
    logic signed [SW-1:0] y_val;
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] sy;
    logic signed [EW-1:0] xv;
    logic signed [EW-1:0] yv;
    logic signed [EW-1:0] thr;
    logic [HEAD_W-1:0]    head_next;
    logic                 accept;
    logic                 out_free;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_rest_reg      <= RST_X_REST;
            y_rest_reg      <= RST_Y_REST;
            x_dead_zone_reg <= RST_X_DEAD_ZONE;
            y_dead_zone_reg <= RST_Y_DEAD_ZONE;
            orientation_reg <= RST_ORIENTATION;
            threshold_reg   <= RST_THRESHOLD;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_X_REST:      x_rest_reg      <= cfg.data;
                CFG_Y_REST:      y_rest_reg      <= cfg.data;
                CFG_X_DEAD_ZONE: x_dead_zone_reg <= cfg.data;
                CFG_Y_DEAD_ZONE: y_dead_zone_reg <= cfg.data;
                CFG_ORIENTATION: orientation_reg <= cfg.data[ORIENT_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg.data[THRESH_W-1:0];
                default:         ;
            endcase
        end
    end

    // One serial scaling unit per axis; both finish in the same cycle.
    jac_axis #(
        .ADC_FULL_SCALE(ADC_FULL_SCALE),
        .OUT_SCALE     (OUT_SCALE)
    ) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .raw      (raw_x_reg),
        .rest     (x_rest_reg),
        .dead_zone(x_dead_zone_reg),
        .done     (x_done),
        .value    (x_val)
    );

    jac_axis #(
        .ADC_FULL_SCALE(ADC_FULL_SCALE),
        .OUT_SCALE     (OUT_SCALE)
    ) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .raw      (raw_y_reg),
        .rest     (y_rest_reg),
        .dead_zone(y_dead_zone_reg),
        .done     (y_done),
        .value    (y_val)
    );

    // Rotation and direction class of the finished axis values.
    always_comb
    begin
        sx  = EW'(x_val);
        sy  = EW'(y_val);
        thr = $signed(EW'(threshold_reg));
        case (orientation_reg)
            ORIENT_0:
            begin
                xv = sx;
                yv = sy;
            end
            ORIENT_180:
            begin
                xv = sy;
                yv = sx;
            end
            default:
            begin
                // Quarter turns in either direction map the same way.
                xv = -sy;
                yv = -sx;
            end
        endcase
        if (xv < -thr)
        begin
            head_next = HEAD_LEFT;
        end
        else if (xv > thr)
        begin
            head_next = HEAD_RIGHT;
        end
        else if (yv > thr)
        begin
            head_next = HEAD_UP;
        end
        else if (yv < -thr)
        begin
            head_next = HEAD_DOWN;
        end
        else
        begin
            head_next = HEAD_NONE;
        end
    end

    assign accept   = sample.valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    // Sample capture, sequencing and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            raw_x_reg       <= '0;
            raw_y_reg       <= '0;
            start_reg       <= 1'b0;
            last_button_reg <= 1'b1;
            press_reg       <= 1'b0;
            res_x_reg       <= '0;
            res_y_reg       <= '0;
            res_press_reg   <= 1'b0;
            res_head_reg    <= HEAD_NONE;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_press_reg   <= 1'b0;
            out_head_reg    <= HEAD_NONE;
        end
        else
        begin
            // The axis units start in the cycle after a sample is taken.
            start_reg <= accept;
            // A taken result leaves unless a new one replaces it in this cycle.
            if (out_valid_reg && result.ready && (state_reg != ST_PUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        raw_x_reg       <= sample.raw_x;
                        raw_y_reg       <= sample.raw_y;
                        press_reg       <= !sample.button_level && last_button_reg;
                        last_button_reg <= sample.button_level;
                        state_reg       <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (x_done && y_done)
                    begin
                        res_x_reg     <= xv[OUT_W-1:0];
                        res_y_reg     <= yv[OUT_W-1:0];
                        res_press_reg <= press_reg;
                        res_head_reg  <= head_next;
                        state_reg     <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= res_x_reg;
                        out_y_reg     <= res_y_reg;
                        out_press_reg <= res_press_reg;
                        out_head_reg  <= res_head_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample.ready       = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.x_out       = $signed(out_x_reg);
    assign result.y_out       = $signed(out_y_reg);
    assign result.press_event = out_press_reg;
    assign result.heading     = out_head_reg;

endmodule

[src/jac_checker.sv]
module jac_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         sample_valid,
    input logic                         sample_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [jac_pkg::OUT_W-1:0]    result_x_out,
    input logic [jac_pkg::OUT_W-1:0]    result_y_out,
    input logic [jac_pkg::HEAD_W-1:0]   result_heading
);
    import jac_pkg::*;

    // A result that is not taken stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped before it was taken");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_x_out) && $stable(result_y_out) && $stable(result_heading))
        else $error("stalled result changed its payload");

    // Only one sample is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second sample taken while one is in work");

    // A result cannot follow its sample in the very next cycle.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !$rose(result_valid))
        else $error("result appeared too early after a sample");

    // Configuration writes are never stalled.
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request stalled");

endmodule

bind joystick_axis_conditioner jac_checker u_jac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .sample_valid  (sample.valid),
    .sample_ready  (sample.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_x_out  (result.x_out),
    .result_y_out  (result.y_out),
    .result_heading(result.heading)
);

[tb/sv/tb_joystick_axis_conditioner.sv]
`timescale 1ns / 1ps

module tb_joystick_axis_conditioner;
    import jac_pkg::*;

    // Full-scale ADC reading and output span of the default build.
    localparam int ADC_MAX = 4095;
    localparam int OUT_SPAN = 100;

    // Waiting time after the last result, with a little margin over one sample's run.
    localparam int BLOCK_LATENCY = 16;
    localparam int END_SETTLE = 40;
    localparam int STALL_LIMIT = 2000;

    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_CORNERS = 7;
    localparam int NUM_ROWS = 18;

    // Register indexes that no register answers to.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic [OUT_W-1:0] POS_FULL = 8'd100;
    localparam logic [OUT_W-1:0] NEG_FULL = -8'sd100;
    localparam logic [OUT_W-1:0] CENTER = 8'd0;

    typedef struct packed {
        logic [OUT_W-1:0]  x_val;
        logic [OUT_W-1:0]  y_val;
        logic              press;
        logic [HEAD_W-1:0] heading;
    } stick_result_t;

    typedef struct packed {
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        logic             btn;
        logic             use_table;
        stick_result_t    want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    jac_cfg_if cfg_if ();
    jac_in_if  sample_if ();
    jac_out_if result_if ();

    joystick_axis_conditioner u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if.sink),
        .sample (sample_if.sink),
        .result (result_if.source)
    );

    // Shadow copies of the configuration registers and the button history.
    logic [RAW_W-1:0]    cfg_x_rest = RST_X_REST;
    logic [RAW_W-1:0]    cfg_y_rest = RST_Y_REST;
    logic [RAW_W-1:0]    cfg_x_dz   = RST_X_DEAD_ZONE;
    logic [RAW_W-1:0]    cfg_y_dz   = RST_Y_DEAD_ZONE;
    logic [ORIENT_W-1:0] cfg_orient = RST_ORIENTATION;
    logic [THRESH_W-1:0] cfg_thresh = RST_THRESHOLD;
    logic                last_btn   = 1'b1;

    logic [ORIENT_W-1:0] orient_cycle [4] = '{ORIENT_0, ORIENT_90, ORIENT_180, ORIENT_270};

    stick_result_t conditioned_q [$];
    int            n_errors = 0;
    int            quiet_cycles = 0;
    bit            idle_on = 1'b1;

    // Directed samples under the reset configuration; the obvious results are typed in.
    dir_row_t directed_rows [NUM_ROWS] = '{
        '{12'd2048, 12'd2048, 1'b1, 1'b1, '{CENTER, CENTER, 1'b0, HEAD_NONE}},
        '{12'd4095, 12'd2048, 1'b1, 1'b1, '{POS_FULL, CENTER, 1'b0, HEAD_RIGHT}},
        '{12'd0,    12'd2048, 1'b1, 1'b1, '{NEG_FULL, CENTER, 1'b0, HEAD_LEFT}},
        '{12'd2048, 12'd4095, 1'b0, 1'b1, '{CENTER, POS_FULL, 1'b1, HEAD_UP}},
        '{12'd2048, 12'd0,    1'b0, 1'b1, '{CENTER, NEG_FULL, 1'b0, HEAD_DOWN}},
        '{12'd2048, 12'd0,    1'b1, 1'b1, '{CENTER, NEG_FULL, 1'b0, HEAD_DOWN}},
        '{12'd0,    12'd0,    1'b0, 1'b1, '{NEG_FULL, NEG_FULL, 1'b1, HEAD_LEFT}},
        '{12'd4095, 12'd4095, 1'b1, 1'b1, '{POS_FULL, POS_FULL, 1'b0, HEAD_RIGHT}},
        '{12'd2097, 12'd2082, 1'b1, 1'b1, '{CENTER, CENTER, 1'b0, HEAD_NONE}},
        '{12'd2098, 12'd2013, 1'b0, 1'b0, '0},
        '{12'd1998, 12'd2083, 1'b0, 1'b0, '0},
        '{12'd2867, 12'd2048, 1'b1, 1'b0, '0},
        '{12'd2888, 12'd1228, 1'b1, 1'b0, '0},
        '{12'd4094, 12'd1,    1'b0, 1'b0, '0},
        '{12'hAAA,  12'h555,  1'b1, 1'b0, '0},
        '{12'h555,  12'hAAA,  1'b0, 1'b0, '0},
        '{12'd1,    12'd4094, 1'b1, 1'b0, '0},
        '{12'd2048, 12'd2867, 1'b0, 1'b0, '0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scale one axis reading against its rest value and dead zone.
    function automatic int scale_reading(input int raw, input int rest, input int dz);
        int delta;
        delta = (raw > rest) ? raw - rest : rest - raw;
        if (delta < dz)
            return 0;
        if (raw > rest)
        begin
            // Readings at full scale saturate and keep the divisor positive.
            if (raw >= ADC_MAX || rest >= ADC_MAX)
                return OUT_SPAN;
            return ((raw - rest) * OUT_SPAN) / (ADC_MAX - rest);
        end
        // A rest of zero leaves only the reading zero below it.
        if (rest == 0)
            return 0;
        return (raw * OUT_SPAN) / rest - OUT_SPAN;
    endfunction

    // Work out the conditioned result of one sample and advance the button history.
    function automatic stick_result_t condition_sample(input logic [RAW_W-1:0] rx,
                                                      input logic [RAW_W-1:0] ry,
                                                      input logic btn);
        int sx;
        int sy;
        int xv;
        int yv;
        int t;
        stick_result_t res;
        sx = scale_reading(int'(rx), int'(cfg_x_rest), int'(cfg_x_dz));
        sy = scale_reading(int'(ry), int'(cfg_y_rest), int'(cfg_y_dz));
        // The 90 and 270 degree mountings map identically.
        case (cfg_orient)
            ORIENT_0:
            begin
                xv = sx;
                yv = sy;
            end
            ORIENT_180:
            begin
                xv = sy;
                yv = sx;
            end
            default:
            begin
                xv = -sy;
                yv = -sx;
            end
        endcase
        t = int'(cfg_thresh);
        res.x_val = xv[OUT_W-1:0];
        res.y_val = yv[OUT_W-1:0];
        res.press = (btn == 1'b0 && last_btn == 1'b1);
        last_btn = btn;
        if (xv < -t)
            res.heading = HEAD_LEFT;
        else if (xv > t)
            res.heading = HEAD_RIGHT;
        else if (yv > t)
            res.heading = HEAD_UP;
        else if (yv < -t)
            res.heading = HEAD_DOWN;
        else
            res.heading = HEAD_NONE;
        return res;
    endfunction

    // Mirror a register write into the shadow copies.
    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_X_REST:      cfg_x_rest = value;
            CFG_Y_REST:      cfg_y_rest = value;
            CFG_X_DEAD_ZONE: cfg_x_dz = value;
            CFG_Y_DEAD_ZONE: cfg_y_dz = value;
            CFG_ORIENTATION: cfg_orient = value[ORIENT_W-1:0];
            CFG_THRESHOLD:   cfg_thresh = value[THRESH_W-1:0];
            default: ;
        endcase
    endfunction

    // Readings around the interesting points of one axis, clamped to the ADC range.
    function automatic logic [RAW_W-1:0] corner_reading(input int rest, input int dz,
                                                        input int k);
        int v;
        case (k)
            0:       v = 0;
            1:       v = ADC_MAX;
            2:       v = rest;
            3:       v = rest + dz;
            4:       v = rest + dz - 1;
            5:       v = rest - dz;
            default: v = rest - dz + 1;
        endcase
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return v[RAW_W-1:0];
    endfunction

    // Random reading, weighted toward the dead-zone edges and the rails.
    function automatic logic [RAW_W-1:0] pick_reading(input int rest, input int dz);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, ADC_MAX));
            4, 5, 6:    v = int'($urandom_range(0, 2 * dz + 40)) + rest - dz - 20;
            7:          v = int'(corner_reading(rest, dz,
                                                int'($urandom_range(2, NUM_CORNERS - 1))));
            8:          v = $urandom_range(0, 1) ? ADC_MAX : 0;
            default:    v = $urandom_range(0, 1) ? 'hAAA : 'h555;
        endcase
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return v[RAW_W-1:0];
    endfunction

    // Present one sample request, wait for it to be taken and record its result.
    task automatic submit_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                                 input logic btn, input logic use_table,
                                 input stick_result_t table_res);
        int gap;
        stick_result_t predicted;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid = 1'b1;
        sample_if.raw_x = rx;
        sample_if.raw_y = ry;
        sample_if.button_level = btn;
        do @(posedge clk); while (!sample_if.ready);
        predicted = condition_sample(rx, ry, btn);
        conditioned_q.push_back(use_table ? table_res : predicted);
    endtask

    task automatic release_sample();
        @(negedge clk);
        sample_if.valid = 1'b0;
    endtask

    // Wait until every outstanding result has come back and the block is quiet.
    task automatic wait_conditioned();
        while (conditioned_q.size() != 0)
            @(posedge clk);
        repeat (BLOCK_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        do @(posedge clk); while (!cfg_if.ready);
        apply_setting(idx, value);
    endtask

    // Program the registers for one phase; upper data bits of narrow registers carry junk.
    task automatic configure_phase(input int p);
        logic [CFG_DATA_W-1:0] orient_word;
        logic [CFG_DATA_W-1:0] thresh_word;
        orient_word = CFG_DATA_W'($urandom());
        thresh_word = CFG_DATA_W'($urandom());
        case (p)
            0:
            begin
                write_reg(CFG_X_REST, 12'd0);
                write_reg(CFG_Y_REST, 12'd0);
                write_reg(CFG_X_DEAD_ZONE, 12'd1);
                write_reg(CFG_Y_DEAD_ZONE, 12'd1);
                orient_word[ORIENT_W-1:0] = ORIENT_90;
                thresh_word[THRESH_W-1:0] = 7'd0;
            end
            1:
            begin
                write_reg(CFG_X_REST, 12'd4095);
                write_reg(CFG_Y_REST, 12'd4095);
                write_reg(CFG_X_DEAD_ZONE, 12'd4095);
                write_reg(CFG_Y_DEAD_ZONE, 12'd4095);
                orient_word[ORIENT_W-1:0] = ORIENT_180;
                thresh_word[THRESH_W-1:0] = 7'd127;
            end
            2:
            begin
                write_reg(CFG_X_REST, 12'd4095);
                write_reg(CFG_Y_REST, 12'd0);
                write_reg(CFG_X_DEAD_ZONE, 12'd0);
                write_reg(CFG_Y_DEAD_ZONE, 12'd0);
                orient_word[ORIENT_W-1:0] = ORIENT_270;
                thresh_word[THRESH_W-1:0] = 7'd100;
            end
            3:
            begin
                write_reg(CFG_X_REST, RST_X_REST);
                write_reg(CFG_Y_REST, RST_Y_REST);
                write_reg(CFG_X_DEAD_ZONE, RST_X_DEAD_ZONE);
                write_reg(CFG_Y_DEAD_ZONE, RST_Y_DEAD_ZONE);
                orient_word[ORIENT_W-1:0] = ORIENT_0;
                thresh_word[THRESH_W-1:0] = RST_THRESHOLD;
            end
            default:
            begin
                write_reg(CFG_X_REST, CFG_DATA_W'($urandom_range(0, ADC_MAX)));
                write_reg(CFG_Y_REST, CFG_DATA_W'($urandom_range(0, ADC_MAX)));
                write_reg(CFG_X_DEAD_ZONE, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, ADC_MAX) : $urandom_range(0, 120)));
                write_reg(CFG_Y_DEAD_ZONE, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, ADC_MAX) : $urandom_range(0, 120)));
                orient_word[ORIENT_W-1:0] = orient_cycle[p % 4];
                thresh_word[THRESH_W-1:0] = THRESH_W'($urandom_range(0, 127));
            end
        endcase
        write_reg(CFG_ORIENTATION, orient_word);
        write_reg(CFG_THRESHOLD, thresh_word);
        // Writes to unused indexes must leave every register alone.
        if (p == 4)
        begin
            write_reg(CFG_SPARE_6, 12'hFFF);
            write_reg(CFG_SPARE_7, 12'hA5C);
        end
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            result_if.ready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        stick_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (conditioned_q.size() == 0)
            begin
                $error("unexpected result: x_out %0d y_out %0d", result_if.x_out,
                       result_if.y_out);
                n_errors++;
            end
            else
            begin
                want = conditioned_q.pop_front();
                if (result_if.x_out !== want.x_val)
                begin
                    $error("x_out: expected %0d, actual %0d", $signed(want.x_val),
                           result_if.x_out);
                    n_errors++;
                end
                if (result_if.y_out !== want.y_val)
                begin
                    $error("y_out: expected %0d, actual %0d", $signed(want.y_val),
                           result_if.y_out);
                    n_errors++;
                end
                if (result_if.press_event !== want.press)
                begin
                    $error("press_event: expected %0d, actual %0d", want.press,
                           result_if.press_event);
                    n_errors++;
                end
                if (result_if.heading !== want.heading)
                begin
                    $error("heading: expected %0d, actual %0d", want.heading,
                           result_if.heading);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any request moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready) ||
            (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_joystick_axis_conditioner: errors");
            $finish;
        end
    end

    // Main sequence: directed samples, then configuration phases with random samples.
    initial
    begin
        logic btn_drive;
        sample_if.valid = 1'b0;
        sample_if.raw_x = '0;
        sample_if.raw_y = '0;
        sample_if.button_level = 1'b1;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_X_REST;
        cfg_if.data = '0;
        btn_drive = 1'b1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            submit_sample(directed_rows[r].rx, directed_rows[r].ry, directed_rows[r].btn,
                          directed_rows[r].use_table, directed_rows[r].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            release_sample();
            wait_conditioned();
            configure_phase(p);
            // Some phases run without idling; the last one never idles.
            idle_on = (p != NUM_PHASES - 1) && (p % 3 != 2);

            // Edge readings of both axes under the new setting.
            for (int k = 0; k < NUM_CORNERS; k++)
                submit_sample(corner_reading(int'(cfg_x_rest), int'(cfg_x_dz), k),
                              corner_reading(int'(cfg_y_rest), int'(cfg_y_dz),
                                             (k + 3) % NUM_CORNERS),
                              k[0], 1'b0, '0);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    btn_drive = ~btn_drive;
                submit_sample(pick_reading(int'(cfg_x_rest), int'(cfg_x_dz)),
                              pick_reading(int'(cfg_y_rest), int'(cfg_y_dz)), btn_drive,
                              1'b0, '0);
                // Now and then hold off until the block has drained completely.
                if ($urandom_range(0, 59) == 0)
                begin
                    release_sample();
                    wait_conditioned();
                end
            end
        end

        release_sample();
        while (conditioned_q.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (n_errors == 0)
            $display("tb_joystick_axis_conditioner: clean");
        else
            $display("tb_joystick_axis_conditioner: errors");
        $finish;
    end

endmodule

[sim.f]
src/jac_pkg.sv
src/jac_if.sv
src/jac_axis.sv
src/joystick_axis_conditioner.sv
src/jac_checker.sv
tb/sv/tb_joystick_axis_conditioner.sv
